[design/signed_integer_divider_macros.svh]
// assertion macros shared by the divider checker
`ifndef SIGNED_INTEGER_DIVIDER_MACROS_SVH
`define SIGNED_INTEGER_DIVIDER_MACROS_SVH

// property checked only outside reset
`define SID_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("divider assertion failed");

// property checked on every edge, reset included
`define SID_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("divider assertion failed");

`endif

[design/sid_pkg.sv]
// package with widths, constants and the pipeline stage type of the divider
`default_nettype none

package sid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int S_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int NUM_STEPS = DATA_WIDTH;

    localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ZERO = '0;

    // one word in flight through the divide pipeline
    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic                  dbz;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] dsr;
    } sid_stage_t;

endpackage

`default_nettype wire

[design/sid_step.sv]
// one restoring divide step with its pipeline register
`default_nettype none

module sid_step (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire sid_pkg::sid_stage_t stage_in,
    output sid_pkg::sid_stage_t     stage_out
);

    sid_pkg::sid_stage_t stage_reg;
    sid_pkg::sid_stage_t stage_next;
    logic [sid_pkg::DATA_WIDTH:0] trial;
    logic [sid_pkg::DATA_WIDTH:0] diff;

    always_comb begin
        trial = {stage_in.rem, stage_in.acc[sid_pkg::DATA_WIDTH-1]};
        diff = trial - {1'b0, stage_in.dsr};
        stage_next = stage_in;
        if (!diff[sid_pkg::DATA_WIDTH]) begin
            stage_next.rem = diff[sid_pkg::DATA_WIDTH-1:0];
        end else begin
            stage_next.rem = trial[sid_pkg::DATA_WIDTH-1:0];
        end
        // dividend bit shifts out, quotient bit shifts in
        stage_next.acc = {stage_in.acc[sid_pkg::DATA_WIDTH-2:0], ~diff[sid_pkg::DATA_WIDTH]};
    end

    // only the valid bit is cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

[design/signed_integer_divider.sv]
// signed integer divider, fully pipelined restoring division
// usage:
//   s_ channel takes one word per handshake: dividend and divisor, signed
//   m_ channel returns one word per input word, in order: the quotient
//   truncated toward zero and a divide-by-zero flag in m_tuser
//   most negative dividend over minus one saturates to the largest positive
//   value; a zero divisor gives quotient zero with the flag set
// pipeline: one operand stage for sign and magnitudes, one stage per
//   quotient bit, one output stage for sign fix and saturation
// throughput: one word per cycle while not stalled; every stage holds its own word
// stall: the whole pipeline freezes while m_tvalid is high and m_tready low;
//   s_tready then drops, and nothing is lost or repeated
// reset: aresetn low clears every valid bit, so the pipeline comes up empty
//   and m_tvalid is low; payload registers are not cleared
`default_nettype none

module signed_integer_divider (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // dividend [31:0], divisor [63:32]
    input  wire logic [sid_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // quotient [31:0]
    output logic [sid_pkg::M_TDATA_WIDTH-1:0]      m_tdata,
    // divide_by_zero [0]
    output logic [0:0]                             m_tuser
);

    localparam int W = sid_pkg::DATA_WIDTH;

    // global advance: the output register is free or being drained
    logic advance;

    // operand decode
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [W-1:0] dividend_mag;
    logic [W-1:0] divisor_mag;

    // stage chain, index 0 is the operand register
    sid_pkg::sid_stage_t chain [0:sid_pkg::NUM_STEPS];
    sid_pkg::sid_stage_t op_reg;
    sid_pkg::sid_stage_t op_next;

    // result stage
    sid_pkg::sid_stage_t last;
    logic [W-1:0] quotient_next;
    logic [W-1:0] quotient_reg;
    logic         dbz_reg;
    logic         m_valid_reg;

    assign advance = !m_valid_reg || m_tready;
    assign s_tready = advance;

    assign dividend = s_tdata[W-1:0];
    assign divisor = s_tdata[2*W-1:W];

    // two's complement magnitude; the most negative value maps to 2^(W-1)
    assign dividend_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
    assign divisor_mag = divisor[W-1] ? (~divisor + 1'b1) : divisor;

    always_comb begin
        op_next.valid = s_tvalid;
        op_next.neg = dividend[W-1] ^ divisor[W-1];
        op_next.dbz = (divisor == sid_pkg::ZERO);
        op_next.rem = '0;
        op_next.acc = dividend_mag;
        op_next.dsr = divisor_mag;
    end

    // operand register; reset clears only the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg.valid <= 1'b0;
        end else if (advance) begin
            op_reg <= op_next;
        end
    end

    assign chain[0] = op_reg;

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < sid_pkg::NUM_STEPS; i++) begin : g_step
        sid_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign last = chain[sid_pkg::NUM_STEPS];

    // sign fix, overflow saturation and zero divisor override
    always_comb begin
        if (last.dbz) begin
            quotient_next = sid_pkg::ZERO;
        end else if (last.neg) begin
            quotient_next = ~last.acc + 1'b1;
        end else if (last.acc[W-1]) begin
            // only 2^(W-1) can land here: most negative over minus one
            quotient_next = sid_pkg::INT_MAX;
        end else begin
            quotient_next = last.acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            quotient_reg <= quotient_next;
            dbz_reg <= last.dbz;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {{(sid_pkg::M_TDATA_WIDTH - W){1'b0}}, quotient_reg};
    assign m_tuser = dbz_reg;

endmodule

`default_nettype wire

[design/sid_checker.sv]
// port-level checker for the divider and its bind
`default_nettype none
`include "signed_integer_divider_macros.svh"

module sid_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [sid_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [sid_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input wire logic [0:0]                        m_tuser
);

    // a stalled result word stays put
    `SID_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a divide-by-zero word carries quotient zero
    `SID_ASSERT(a_dbz_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata == '0)

    // a stalled output freezes the whole pipe, input included
    `SID_ASSERT(a_stall_backpressure, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready)

    // with the output empty the pipe always moves
    `SID_ASSERT(a_idle_ready, aclk, aresetn, !m_tvalid |-> s_tready)

    // reset empties the pipeline
    `SID_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind signed_integer_divider sid_checker u_sid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[test/tb_signed_integer_divider.sv]
// testbench for the signed integer divider with directed and random operands
module tb_signed_integer_divider;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH = sid_pkg::DATA_WIDTH;
    localparam int S_TDATA_WIDTH = sid_pkg::S_TDATA_WIDTH;
    localparam int M_TDATA_WIDTH = sid_pkg::M_TDATA_WIDTH;
    localparam int NUM_STEPS = sid_pkg::NUM_STEPS;
    localparam logic [DATA_WIDTH-1:0] INT_MAX = sid_pkg::INT_MAX;
    localparam logic [DATA_WIDTH-1:0] ZERO = sid_pkg::ZERO;

    localparam int MAX_STALL = 12;
    localparam int DRAIN_CYCLES = NUM_STEPS + 8;

    // one result word as the block should return it
    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic                  divide_by_zero;
    } quotient_word_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // dividend [31:0], divisor [63:32]
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // quotient [31:0]
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    // divide_by_zero [0]
    logic [0:0]               m_tuser;

    // quotients still owed by the block, oldest first
    quotient_word_t pending_quotients[$];
    int             error_count = 0;
    bit             idling_on = 1'b1;

    signed_integer_divider dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // truncating division on magnitudes, sign from the operand signs
    function automatic quotient_word_t predict_quotient(logic [DATA_WIDTH-1:0] dividend,
                                                        logic [DATA_WIDTH-1:0] divisor);
        quotient_word_t        word;
        logic [DATA_WIDTH-1:0] mag_dividend;
        logic [DATA_WIDTH-1:0] mag_divisor;
        logic [DATA_WIDTH-1:0] mag_quotient;
        logic                  negative;
        word = '0;
        if (divisor == ZERO) begin
            // zero divisor: quotient zero, flag set, dividend ignored
            word.divide_by_zero = 1'b1;
            return word;
        end
        negative = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        // the most negative value negates to itself, which reads as 2^(n-1) unsigned
        mag_dividend = dividend[DATA_WIDTH-1] ? -dividend : dividend;
        mag_divisor = divisor[DATA_WIDTH-1] ? -divisor : divisor;
        mag_quotient = mag_dividend / mag_divisor;
        if (negative) begin
            word.quotient = -mag_quotient;
        end else if (mag_quotient > INT_MAX) begin
            // most negative over minus one saturates
            word.quotient = INT_MAX;
        end else begin
            word.quotient = mag_quotient;
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] wanted,
                                   input logic [DATA_WIDTH-1:0] seen);
        $display("%t mismatch on %s: expected %h, got %h", $realtime, what, wanted, seen);
        error_count++;
    endtask

    // drive one operand pair and wait for its handshake
    task automatic send_division(input logic [DATA_WIDTH-1:0] dividend,
                                 input logic [DATA_WIDTH-1:0] divisor);
        logic [S_TDATA_WIDTH-1:0] word;
        // sender gap in a burst of idle cycles
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_STALL)) @(posedge aclk);
        end
        word = '0;
        word[DATA_WIDTH-1:0] = dividend;
        word[2*DATA_WIDTH-1:DATA_WIDTH] = divisor;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        pending_quotients.insert(pending_quotients.size(), predict_quotient(dividend, divisor));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_for_drain();
        while (pending_quotients.size() != 0) @(posedge aclk);
    endtask

    // operand mix: corner values, small numbers, powers of two, full range
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] value;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: value = ZERO;
                    1: value = 1;
                    2: value = '1;
                    3: value = INT_MAX;
                    4: value = ~INT_MAX;
                    default: value = ~INT_MAX + 1;
                endcase
            end
            1, 2, 3: value = $urandom_range(0, 510) - 255;
            4: begin
                value = {{(DATA_WIDTH - 1){1'b0}}, 1'b1} << $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1)) value = -value;
            end
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // every special case and the field extremes
    task automatic test_corner_cases();
        logic [DATA_WIDTH-1:0] int_min;
        logic [DATA_WIDTH-1:0] minus_one;
        int_min = ~INT_MAX;
        minus_one = '1;
        send_division(ZERO, 1);
        send_division(1, 1);
        send_division(INT_MAX, 1);
        send_division(int_min, 1);
        send_division(int_min, minus_one);    // overflow, saturates
        send_division(int_min, int_min);
        send_division(INT_MAX, int_min);
        send_division(INT_MAX, INT_MAX);
        send_division(int_min, INT_MAX);
        send_division(int_min, 2);            // magnitude of the most negative value
        send_division(7, -2);
        send_division(-7, 2);
        send_division(-7, -2);
        send_division(5, ZERO);               // zero divisor
        send_division(int_min, ZERO);
        send_division(ZERO, ZERO);
        send_division(minus_one, ZERO);
        send_division(3, 7);
        send_division(minus_one, minus_one);
        send_division(1, minus_one);
        send_division(INT_MAX, minus_one);
        send_division(minus_one, int_min);
        send_division(ZERO, minus_one);
        send_division(ZERO, int_min);
        stop_sending();
    endtask

    task automatic test_random_operands(input int count);
        repeat (count) send_division(pick_operand(), pick_operand());
        stop_sending();
    endtask

    // small operands exercise the remainder path
    task automatic test_small_operands(input int count);
        logic [DATA_WIDTH-1:0] divisor;
        repeat (count) begin
            divisor = $urandom_range(0, 32) - 16;
            send_division($urandom_range(0, 8000) - 4000, divisor);
        end
        stop_sending();
    endtask

    // sender holds off until the pipeline has emptied, then sends again
    task automatic test_drain_between_bursts(input int bursts);
        repeat (bursts) begin
            repeat ($urandom_range(10, 40)) send_division(pick_operand(), pick_operand());
            stop_sending();
            wait_for_drain();
        end
    endtask

    // no idling on either side: full rate through the pipeline
    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        repeat (count) send_division(pick_operand(), pick_operand());
        stop_sending();
    endtask

    // result side: bursts of stall while idling is on
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && idling_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_STALL)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each returned word with the oldest pending quotient
    always @(posedge aclk) begin
        quotient_word_t wanted;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_quotients.size() == 0) begin
                report_mismatch("unexpected word", ZERO, m_tdata[DATA_WIDTH-1:0]);
            end else begin
                wanted = pending_quotients.pop_front();
                if (m_tdata[DATA_WIDTH-1:0] !== wanted.quotient)
                    report_mismatch("quotient", wanted.quotient, m_tdata[DATA_WIDTH-1:0]);
                if (m_tuser[0] !== wanted.divide_by_zero)
                    report_mismatch("divide_by_zero", DATA_WIDTH'(wanted.divide_by_zero),
                                    DATA_WIDTH'(m_tuser[0]));
            end
        end
    end

    // generous limit on the whole run
    initial begin
        #(64'd8_000_000);
        $display("** signed_integer_divider: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_cases();
        test_random_operands(250);
        test_drain_between_bursts(3);
        test_small_operands(150);
        test_random_operands(100);
        test_back_to_back(150);

        wait_for_drain();
        // let any stray word show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_quotients.size() == 0) begin
            $display("** signed_integer_divider: PASSED **");
        end else begin
            $display("** signed_integer_divider: FAILED **");
        end
        $finish;
    end

endmodule
